### rtl/page_table_mapper_3level_assert.svh
`ifndef PAGE_TABLE_MAPPER_3LEVEL_ASSERT_SVH
`define PAGE_TABLE_MAPPER_3LEVEL_ASSERT_SVH

// same-cycle implication, clocked on clk, off while arst_n is low
`define PTM_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ptm assertion failed");

// next-cycle implication, clocked on clk, off while arst_n is low
`define PTM_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ptm assertion failed");

`endif

### rtl/ptm_pkg.sv
package ptm_pkg;

	localparam int CFG_ADDR_W = 5;

	localparam logic [1:0] REG_POOL_BASE  = 2'd0;
	localparam logic [1:0] REG_ROOT_TABLE = 2'd1;
	localparam logic [1:0] REG_FIRST_FREE = 2'd2;

	localparam logic [63:0] D_VALID     = 64'h1;
	localparam logic [63:0] D_TABLE     = 64'h1 << 1;
	localparam logic [63:0] D_ATTR1     = 64'h1 << 2;
	localparam logic [63:0] D_AF        = 64'h1 << 10;
	localparam logic [63:0] D_NG        = 64'h1 << 11;
	localparam logic [63:0] D_PXN       = 64'h1 << 53;
	localparam logic [63:0] D_UXN       = 64'h1 << 54;
	localparam logic [63:0] AP_RW_EL0   = 64'h1 << 6;
	localparam logic [63:0] AP_RO_EL1   = 64'h2 << 6;
	localparam logic [63:0] AP_RO_EL0   = 64'h3 << 6;
	localparam logic [63:0] SH_OUTER    = 64'h2 << 8;
	localparam logic [63:0] SHARE_INNER = 64'h3 << 8;

	typedef enum logic [1:0] {
		ST_MAPPED   = 2'd0,
		ST_ALREADY  = 2'd1,
		ST_NO_PAGES = 2'd2
	} status_t;

	typedef struct packed {
		logic [35:0] pool_base;
		logic [5:0]  root_table;
		logic [6:0]  next_free;
	} cfg_t;

	typedef struct packed {
		logic       valid;
		logic [6:0] next_free;
	} alloc_upd_t;

	function automatic logic [63:0] make_leaf(input logic [35:0] frame, input logic [3:0] flags);
		logic [63:0] d;
		d = {16'd0, frame, 12'd0} | D_VALID | D_TABLE | D_AF;
		if (flags[3]) begin
			d = d | D_ATTR1 | SH_OUTER | D_UXN | D_PXN;
		end else begin
			d = d | SHARE_INNER;
		end
		if (flags[2]) begin
			d = d | (flags[0] ? AP_RW_EL0 : AP_RO_EL0) | D_PXN | D_NG;
			if (!flags[1]) begin
				d = d | D_UXN;
			end
		end else begin
			if (!flags[0]) begin
				d = d | AP_RO_EL1;
			end
			d = d | D_UXN;
			if (!flags[1]) begin
				d = d | D_PXN;
			end
		end
		return d;
	endfunction

endpackage

### rtl/ptm_regs.sv
module ptm_regs import ptm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [63:0]           pwdata,
	output logic [63:0]           prdata,
	output logic                  pready,
	input  alloc_upd_t            upd,
	output cfg_t                  cfg
);

	logic [35:0] pool_base_q;
	logic [5:0]  root_table_q;
	logic [6:0]  first_free_q;
	logic [6:0]  next_free_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q  <= 36'd0;
			root_table_q <= 6'd0;
			first_free_q <= 7'd1;
			next_free_q  <= 7'd1;
		end else begin
			if (wr_en) begin
				case (paddr[4:3])
					REG_POOL_BASE:  pool_base_q  <= pwdata[35:0];
					REG_ROOT_TABLE: root_table_q <= pwdata[5:0];
					REG_FIRST_FREE: begin
						first_free_q <= pwdata[6:0];
						next_free_q  <= pwdata[6:0];
					end
					default: ;
				endcase
			end else if (upd.valid) begin
				next_free_q <= upd.next_free;
			end
		end
	end

	always_comb begin
		case (paddr[4:3])
			REG_POOL_BASE:  prdata = {28'd0, pool_base_q};
			REG_ROOT_TABLE: prdata = {58'd0, root_table_q};
			REG_FIRST_FREE: prdata = {57'd0, first_free_q};
			default:        prdata = 64'd0;
		endcase
	end

	assign cfg.pool_base  = pool_base_q;
	assign cfg.root_table = root_table_q;
	assign cfg.next_free  = next_free_q;

endmodule

### rtl/ptm_store.sv
module ptm_store import ptm_pkg::*; #(
	parameter int TABLE_PAGES = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               re,
	input  logic                               we,
	input  logic [$clog2(TABLE_PAGES)+8:0]     addr,
	input  logic [63:0]                        wdata,
	output logic [63:0]                        rdata,
	output logic                               clearing
);

	localparam int AW    = $clog2(TABLE_PAGES) + 9;
	localparam int DEPTH = TABLE_PAGES * 512;

	logic [63:0]   mem_q [DEPTH];
	logic [63:0]   rdata_q;
	logic [AW-1:0] clr_q;
	logic          clearing_q;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [63:0]   wr_data;

	// zeroing sweep after reset, one entry per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			if (clr_q == AW'(DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end else begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	assign wr_en   = clearing_q || we;
	assign wr_addr = clearing_q ? clr_q : addr;
	assign wr_data = clearing_q ? 64'd0 : wdata;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata    = rdata_q;
	assign clearing = clearing_q;

endmodule

### rtl/ptm_walker.sv
module ptm_walker import ptm_pkg::*; #(
	parameter int TABLE_PAGES = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           hold,
	input  logic [38:0]                    virt_addr,
	input  logic [47:0]                    phys_addr,
	input  logic [3:0]                     access_flags,
	input  cfg_t                           cfg,
	output logic                           busy,
	output logic                           mem_re,
	output logic                           mem_we,
	output logic [$clog2(TABLE_PAGES)+8:0] mem_addr,
	output logic [63:0]                    mem_wdata,
	input  logic [63:0]                    mem_rdata,
	output alloc_upd_t                     upd,
	output logic                           done,
	output logic [63:0]                    leaf_entry,
	output status_t                        status,
	output logic [6:0]                     tables_used
);

	localparam int PW = $clog2(TABLE_PAGES);
	localparam int AW = PW + 9;
	localparam logic [1:0] LVL_LEAF = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_CHECK,
		S_WRITE_P0,
		S_WRITE_P1,
		S_WRITE_LEAF
	} state_t;

	state_t              state_q;
	logic [1:0]          lvl_q;
	logic [8:0]          idx2_q;
	logic [8:0]          idx3_q;
	logic [35:0]         frame_q;
	logic [3:0]          flags_q;
	logic [6:0]          alloc_q;
	logic [AW-1:0]       addr_q;
	logic [1:0]          pv_q;
	logic [1:0][AW-1:0]  paddr_q;
	logic [1:0][63:0]    pval_q;
	logic                done_q;
	logic [63:0]         leaf_q;
	status_t             status_q;
	logic [6:0]          used_q;

	logic [63:0]   entry;
	logic [35:0]   desc_off;
	logic          desc_out;
	logic          alloc_out;
	logic          root_out;
	logic [63:0]   new_desc;
	logic [PW-1:0] next_page;
	logic [8:0]    next_idx;
	logic [AW-1:0] root_addr;

	// walk's own uncommitted descriptors win over the store
	always_comb begin
		entry = mem_rdata;
		if (pv_q[0] && paddr_q[0] == addr_q) begin
			entry = pval_q[0];
		end
		if (pv_q[1] && paddr_q[1] == addr_q) begin
			entry = pval_q[1];
		end
	end

	assign desc_off  = entry[47:12] - cfg.pool_base;
	assign desc_out  = desc_off >= 36'(TABLE_PAGES);
	assign alloc_out = 32'(alloc_q) >= TABLE_PAGES;
	assign root_out  = 32'(cfg.root_table) >= TABLE_PAGES;
	assign new_desc  = {16'd0, cfg.pool_base + 36'(alloc_q), 12'd0} | D_VALID | D_TABLE;
	assign next_page = entry[0] ? PW'(desc_off) : PW'(alloc_q);
	assign next_idx  = (lvl_q == 2'd0) ? idx2_q : idx3_q;
	assign root_addr = {PW'(cfg.root_table), virt_addr[38:30]};

	always_comb begin
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		mem_addr  = addr_q;
		mem_wdata = leaf_q;
		case (state_q)
			S_READ: mem_re = 1'b1;
			S_WRITE_P0: begin
				mem_we    = pv_q[0];
				mem_addr  = paddr_q[0];
				mem_wdata = pval_q[0];
			end
			S_WRITE_P1: begin
				mem_we    = pv_q[1];
				mem_addr  = paddr_q[1];
				mem_wdata = pval_q[1];
			end
			S_WRITE_LEAF: mem_we = 1'b1;
			default: ;
		endcase
	end

	assign upd.valid     = (state_q == S_WRITE_LEAF);
	assign upd.next_free = alloc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			pv_q    <= 2'b00;
			lvl_q   <= 2'd0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start && !hold) begin
						idx2_q  <= virt_addr[29:21];
						idx3_q  <= virt_addr[20:12];
						frame_q <= phys_addr[47:12];
						flags_q <= access_flags;
						alloc_q <= cfg.next_free;
						pv_q    <= 2'b00;
						lvl_q   <= 2'd0;
						addr_q  <= root_addr;
						if (root_out) begin
							done_q   <= 1'b1;
							leaf_q   <= 64'd0;
							status_q <= ST_NO_PAGES;
							used_q   <= cfg.next_free;
						end else begin
							state_q <= S_READ;
						end
					end
				end
				S_READ: state_q <= S_CHECK;
				S_CHECK: begin
					if (lvl_q == LVL_LEAF) begin
						if (entry[0]) begin
							done_q   <= 1'b1;
							leaf_q   <= entry;
							status_q <= ST_ALREADY;
							used_q   <= cfg.next_free;
							state_q  <= S_IDLE;
						end else begin
							leaf_q  <= make_leaf(frame_q, flags_q);
							state_q <= S_WRITE_P0;
						end
					end else if (entry[0] ? desc_out : alloc_out) begin
						done_q   <= 1'b1;
						leaf_q   <= 64'd0;
						status_q <= ST_NO_PAGES;
						used_q   <= cfg.next_free;
						state_q  <= S_IDLE;
					end else begin
						if (!entry[0]) begin
							pv_q[lvl_q[0]]    <= 1'b1;
							paddr_q[lvl_q[0]] <= addr_q;
							pval_q[lvl_q[0]]  <= new_desc;
							alloc_q           <= alloc_q + 7'd1;
						end
						addr_q  <= {next_page, next_idx};
						lvl_q   <= lvl_q + 2'd1;
						state_q <= S_READ;
					end
				end
				S_WRITE_P0: state_q <= S_WRITE_P1;
				S_WRITE_P1: state_q <= S_WRITE_LEAF;
				S_WRITE_LEAF: begin
					done_q   <= 1'b1;
					status_q <= ST_MAPPED;
					used_q   <= alloc_q;
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign leaf_entry  = leaf_q;
	assign status      = status_q;
	assign tables_used = used_q;

endmodule

### rtl/page_table_mapper_3level.sv
// a new mapping takes three read/check rounds on the single-port table store, then three
// write slots; when the leaf is already valid the walk ends after the third check
// one request at a time; the next start is taken in the cycle done is shown
// reset: registers to defaults, then a zeroing sweep of all TABLE_PAGES*512 entries (busy high)
// done strobes one cycle per request; the receiver cannot stall
module page_table_mapper_3level import ptm_pkg::*; #(
	parameter int TABLE_PAGES = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [38:0]           virt_addr,
	input  logic [47:0]           phys_addr,
	input  logic [3:0]            access_flags,
	output logic                  done,
	output logic [63:0]           leaf_entry,
	output logic [1:0]            status,
	output logic [6:0]            tables_used,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [63:0]           pwdata,
	output logic [63:0]           prdata,
	output logic                  pready
);

	`include "page_table_mapper_3level_assert.svh"

	localparam int AW = $clog2(TABLE_PAGES) + 9;

	cfg_t          cfg;
	alloc_upd_t    upd;
	logic          clearing;
	logic          walk_busy;
	logic          mem_re;
	logic          mem_we;
	logic [AW-1:0] mem_addr;
	logic [63:0]   mem_wdata;
	logic [63:0]   mem_rdata;
	status_t       status_w;

	ptm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.upd     (upd),
		.cfg     (cfg)
	);

	ptm_store #(.TABLE_PAGES(TABLE_PAGES)) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.re       (mem_re),
		.we       (mem_we),
		.addr     (mem_addr),
		.wdata    (mem_wdata),
		.rdata    (mem_rdata),
		.clearing (clearing)
	);

	ptm_walker #(.TABLE_PAGES(TABLE_PAGES)) u_walker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.hold         (clearing),
		.virt_addr    (virt_addr),
		.phys_addr    (phys_addr),
		.access_flags (access_flags),
		.cfg          (cfg),
		.busy         (walk_busy),
		.mem_re       (mem_re),
		.mem_we       (mem_we),
		.mem_addr     (mem_addr),
		.mem_wdata    (mem_wdata),
		.mem_rdata    (mem_rdata),
		.upd          (upd),
		.done         (done),
		.leaf_entry   (leaf_entry),
		.status       (status_w),
		.tables_used  (tables_used)
	);

	assign busy   = walk_busy || clearing;
	assign status = status_w;

	// a result only follows an accepted transfer or a walk in progress
	`PTM_ASSERT_IMP(a_done_has_cause, done, $past(start && !busy) || $past(busy))
	`PTM_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done)
	`PTM_ASSERT_IMP(a_fail_zero_leaf, done && status == ST_NO_PAGES, leaf_entry == 64'd0)
	`PTM_ASSERT_IMP(a_leaf_valid, done && (status == ST_MAPPED || status == ST_ALREADY), leaf_entry[0])

endmodule

### tb/sv/page_table_mapper_3level_tb.sv
module page_table_mapper_3level_tb import ptm_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_PAGES = 64;
	localparam int STORE_WORDS = TABLE_PAGES * 512;
	localparam int CYCLE_LIMIT = 300000;
	localparam int N_PHASES = 8;
	localparam int ITEMS_PER_PHASE = 50;

	typedef struct packed {
		logic [63:0] leaf;
		status_t     st;
		logic [6:0]  used;
	} map_result_t;

	typedef struct packed {
		logic [38:0] va;
		logic [47:0] pa;
		logic [3:0]  fl;
		logic        typed;
		map_result_t want;
	} map_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic [38:0]           virt_addr = '0;
	logic [47:0]           phys_addr = '0;
	logic [3:0]            access_flags = '0;
	logic                  done;
	logic [63:0]           leaf_entry;
	logic [1:0]            status;
	logic [6:0]            tables_used;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [63:0]           pwdata = '0;
	logic [63:0]           prdata;
	logic                  pready;

	// shadow of the table store, allocator and registers
	logic [63:0] pt_mem [0:STORE_WORDS-1];
	logic [35:0] cfg_pool = '0;
	logic [5:0]  cfg_root = '0;
	logic [6:0]  alloc_ptr = 7'd1;
	int          walk_alloc;
	int          pend_addr [0:1];
	logic [63:0] pend_val [0:1];
	int          pend_n;

	map_result_t expected_maps [$];
	map_row_t    dir_rows [$];
	logic [38:0] seen_va [$];

	int cycles = 0;
	int err_count = 0;
	int n_new = 0;
	int n_hit = 0;
	int n_refused = 0;

	page_table_mapper_3level #(
		.TABLE_PAGES(TABLE_PAGES)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.virt_addr(virt_addr),
		.phys_addr(phys_addr),
		.access_flags(access_flags),
		.done(done),
		.leaf_entry(leaf_entry),
		.status(status),
		.tables_used(tables_used),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [63:0] page_pa(input logic [6:0] page);
		logic [35:0] f;
		f = cfg_pool + {29'd0, page};
		return {16'd0, f, 12'd0};
	endfunction

	// store page a descriptor points at, -1 when outside the store
	function automatic int table_page_of(input logic [63:0] desc);
		logic [35:0] idx;
		idx = desc[47:12] - cfg_pool;
		if (idx >= TABLE_PAGES) begin
			return -1;
		end
		return int'(idx);
	endfunction

	// walk reads see the walk's own uncommitted descriptors first
	function automatic logic [63:0] store_peek(input int addr);
		for (int k = pend_n - 1; k >= 0; k--) begin
			if (pend_addr[k] == addr) begin
				return pend_val[k];
			end
		end
		return pt_mem[addr];
	endfunction

	function automatic int walk_level(input int page, input int idx);
		int          addr;
		logic [63:0] e;
		int          np;
		addr = page * 512 + idx;
		e = store_peek(addr);
		if (e[0]) begin
			return table_page_of(e);
		end
		if (walk_alloc >= TABLE_PAGES) begin
			return -1;
		end
		np = walk_alloc;
		pend_addr[pend_n] = addr;
		pend_val[pend_n] = page_pa(np[6:0]) | D_VALID | D_TABLE;
		pend_n++;
		walk_alloc = (walk_alloc + 1) & 127;
		return np;
	endfunction

	function automatic logic [63:0] leaf_desc(input logic [47:0] pa, input logic [3:0] fl);
		logic [63:0] d;
		d = {16'd0, pa[47:12], 12'd0} | D_VALID | D_TABLE | D_AF;
		if (fl[3]) begin
			d = d | D_ATTR1 | SH_OUTER | D_UXN | D_PXN;
		end else begin
			d = d | SHARE_INNER;
		end
		if (fl[2]) begin
			d = d | (fl[0] ? AP_RW_EL0 : AP_RO_EL0) | D_PXN | D_NG;
			if (!fl[1]) begin
				d = d | D_UXN;
			end
		end else begin
			if (!fl[0]) begin
				d = d | AP_RO_EL1;
			end
			d = d | D_UXN;
			if (!fl[1]) begin
				d = d | D_PXN;
			end
		end
		return d;
	endfunction

	// whole walk commits on a new mapping, nothing otherwise
	function automatic map_result_t predict_mapping(input logic [38:0] va, input logic [47:0] pa,
			input logic [3:0] fl);
		map_result_t r;
		int          p2;
		int          p3;
		int          addr;
		logic [63:0] old;
		pend_n = 0;
		walk_alloc = int'(alloc_ptr);
		p2 = -1;
		p3 = -1;
		r.leaf = '0;
		r.st = ST_NO_PAGES;
		if (cfg_root < TABLE_PAGES) begin
			p2 = walk_level(int'(cfg_root), int'(va[38:30]));
		end
		if (p2 >= 0) begin
			p3 = walk_level(p2, int'(va[29:21]));
		end
		if (p3 >= 0) begin
			addr = p3 * 512 + int'(va[20:12]);
			old = store_peek(addr);
			if (old[0]) begin
				r.leaf = old;
				r.st = ST_ALREADY;
			end else begin
				r.leaf = leaf_desc(pa, fl);
				r.st = ST_MAPPED;
				for (int k = 0; k < pend_n; k++) begin
					pt_mem[pend_addr[k]] = pend_val[k];
				end
				pt_mem[addr] = r.leaf;
				alloc_ptr = walk_alloc[6:0];
			end
		end
		pend_n = 0;
		r.used = alloc_ptr;
		return r;
	endfunction

	task automatic issue_map(input logic [38:0] va, input logic [47:0] pa, input logic [3:0] fl);
		@(negedge clk);
		start <= 1'b1;
		virt_addr <= va;
		phys_addr <= pa;
		access_flags <= fl;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
	endtask

	task automatic cfg_write(input logic [1:0] reg_idx, input logic [63:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_idx, 3'b000};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		case (reg_idx)
			REG_POOL_BASE: cfg_pool = val[35:0];
			REG_ROOT_TABLE: cfg_root = val[5:0];
			REG_FIRST_FREE: alloc_ptr = val[6:0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (expected_maps.size() != 0) begin
			@(posedge clk);
		end
		while (busy) begin
			@(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				expected_maps.size());
			$display("** page_table_mapper_3level: FAILED **");
			$finish;
		end
	end

	always @(posedge clk) begin
		map_result_t want;
		if (arst_n && done) begin
			case (status)
				ST_MAPPED: n_new++;
				ST_ALREADY: n_hit++;
				default: n_refused++;
			endcase
			if (expected_maps.size() == 0) begin
				err_count++;
				if (err_count <= 10) begin
					$display("unexpected result: leaf %h status %0d used %0d",
						leaf_entry, status, tables_used);
				end
			end else begin
				want = expected_maps.pop_front();
				if (leaf_entry !== want.leaf || status !== want.st ||
						tables_used !== want.used) begin
					err_count++;
					if (err_count <= 10) begin
						$display("mismatch: leaf %h/%h status %0d/%0d used %0d/%0d (exp/got)",
							want.leaf, leaf_entry, want.st, status, want.used, tables_used);
					end
				end
			end
		end
	end

	initial begin
		map_result_t r;
		map_row_t    row;
		logic [38:0] va;
		logic [63:0] r64;
		logic [8:0]  ws_l1 [0:1];
		logic [8:0]  ws_l2 [0:2];
		logic [35:0] pool_v;
		logic [5:0]  root_v;
		logic [6:0]  ff_v;
		int          pick;
		int          gap;

		for (int a = 0; a < STORE_WORDS; a++) begin
			pt_mem[a] = '0;
		end

		// directed rows, reset configuration: pool 0, root 0, first free 1
		dir_rows.push_back('{39'h0, 48'h0, 4'h0, 1'b1,
			'{64'h0060_0000_0000_0783, ST_MAPPED, 7'd3}});
		dir_rows.push_back('{39'h0, 48'hFFFF_FFFF_FFFF, 4'hF, 1'b1,
			'{64'h0060_0000_0000_0783, ST_ALREADY, 7'd3}});
		dir_rows.push_back('{39'h7F_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 4'hF, 1'b1,
			'{64'h0060_FFFF_FFFF_FE47, ST_MAPPED, 7'd5}});
		for (int k = 0; k < 16; k++) begin
			va = 39'(k + 1);
			row.va = va << 12;
			row.pa = 48'h0123_4567_8ABC ^ (k << 28);
			row.fl = k[3:0];
			row.typed = 1'b0;
			row.want = '0;
			dir_rows.push_back(row);
		end
		// fresh level-2 entry under an existing level-1 table
		dir_rows.push_back('{39'h00_3FE0_0000, 48'hA5A5_5A5A_F000, 4'h6, 1'b0, '0});
		// page offset bits are ignored
		dir_rows.push_back('{39'h00_0000_1FFF, 48'h0, 4'h0, 1'b0, '0});
		dir_rows.push_back('{39'h7F_FFFF_FFFF, 48'h0, 4'h0, 1'b1,
			'{64'h0060_FFFF_FFFF_FE47, ST_ALREADY, 7'd6}});

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		// start is held until the clearing sweep drops busy
		foreach (dir_rows[i]) begin
			issue_map(dir_rows[i].va, dir_rows[i].pa, dir_rows[i].fl);
			r = predict_mapping(dir_rows[i].va, dir_rows[i].pa, dir_rows[i].fl);
			expected_maps.push_back(dir_rows[i].typed ? dir_rows[i].want : r);
			seen_va.push_back(dir_rows[i].va);
		end

		for (int p = 0; p < N_PHASES; p++) begin
			wait_drained();
			pool_v = {4'($urandom_range(15, 0)), $urandom()};
			root_v = 6'($urandom_range(63, 0));
			ff_v = 7'($urandom_range(64, 0));
			case (p)
				0: begin
					pool_v = '0;
					root_v = '0;
					ff_v = alloc_ptr;
				end
				1: begin
					pool_v = 36'hF_FFFF_FFFF;
					root_v = 6'd63;
					ff_v = 7'd0;
				end
				2: begin
					pool_v = '0;
					root_v = '0;
					ff_v = 7'd64;
				end
				4: begin
					pool_v = '0;
					root_v = 6'd40;
					ff_v = 7'd33;
				end
				5: begin
					pool_v = 36'hA_5A5A_5A5A;
					root_v = 6'd21;
					ff_v = 7'd62;
				end
				default: ;
			endcase
			cfg_write(REG_POOL_BASE, {28'd0, pool_v});
			cfg_write(REG_ROOT_TABLE, {58'd0, root_v});
			cfg_write(REG_FIRST_FREE, {57'd0, ff_v});

			ws_l1[0] = 9'($urandom_range(511, 0));
			ws_l1[1] = 9'($urandom_range(511, 0));
			for (int j = 0; j < 3; j++) begin
				ws_l2[j] = 9'($urandom_range(511, 0));
			end

			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				pick = $urandom_range(99, 0);
				if (pick < 25) begin
					va = seen_va[$urandom_range(seen_va.size() - 1, 0)];
					va[11:0] = 12'($urandom_range(4095, 0));
				end else if (pick < 40) begin
					r64 = {$urandom(), $urandom()};
					va = r64[38:0];
				end else begin
					va = {ws_l1[$urandom_range(1, 0)], ws_l2[$urandom_range(2, 0)],
						9'($urandom_range(511, 0)), 12'($urandom_range(4095, 0))};
				end
				r64 = {$urandom(), $urandom()};
				// no idling in the last phase
				if (p != N_PHASES - 1 && $urandom_range(2, 0) == 0) begin
					gap = $urandom_range(19, 1);
					@(negedge clk);
					start <= 1'b0;
					repeat (gap - 1) @(negedge clk);
				end
				issue_map(va, r64[47:0], 4'($urandom_range(15, 0)));
				expected_maps.push_back(predict_mapping(va, r64[47:0], access_flags));
				seen_va.push_back(va);
				if (seen_va.size() > 64) begin
					void'(seen_va.pop_front());
				end
			end
		end

		wait_drained();
		repeat (20) @(posedge clk);
		$display("%0d map requests over %0d register settings plus reset defaults",
			dir_rows.size() + N_PHASES * ITEMS_PER_PHASE, N_PHASES);
		$display("results: %0d new mappings, %0d already mapped, %0d refused, %0d errors",
			n_new, n_hit, n_refused, err_count);
		if (err_count == 0 && expected_maps.size() == 0) begin
			$display("** page_table_mapper_3level: PASSED **");
		end else begin
			$display("** page_table_mapper_3level: FAILED **");
		end
		$finish;
	end

endmodule

### page_table_mapper_3level.f
+incdir+rtl
rtl/ptm_pkg.sv
rtl/ptm_regs.sv
rtl/ptm_store.sv
rtl/ptm_walker.sv
rtl/page_table_mapper_3level.sv
tb/sv/page_table_mapper_3level_tb.sv
